[rtl/core/bsi0_pkg.sv]
// ----------------------------------------------------------------------------
// bsi0_pkg
// Shared types, codes and constants for the I0 power-series evaluator.
// ----------------------------------------------------------------------------
package bsi0_pkg;

	localparam int DEF_MAX_TERMS        = 32;
	localparam int DEF_INPUT_FRAC_BITS  = 16;
	localparam int DEF_OUTPUT_FRAC_BITS = 22;
	localparam int WORK_FRAC            = 32;

	localparam int X_W     = 20;
	localparam int VALUE_W = 32;
	localparam int STAT_W  = 2;
	localparam int ORDER_W = 4;
	localparam int TERMS_W = 6;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int PC_W    = 4;

	// Register indexes (paddr[2])
	localparam logic REG_FUNC_ORDER = 1'b0;
	localparam logic REG_TERM_COUNT = 1'b1;

	localparam logic [ORDER_W-1:0] RST_FUNC_ORDER = 4'd0;
	localparam logic [TERMS_W-1:0] RST_TERM_COUNT = 6'd16;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD_ORDER = 2'd1;
	localparam logic [STAT_W-1:0] ST_SAT       = 2'd2;

	// Multiplier operand A select
	localparam logic [1:0] A_TERM_HI = 2'd0;
	localparam logic [1:0] A_TERM_LO = 2'd1;
	localparam logic [1:0] A_MAG     = 2'd2;

	// Multiplier operand B select
	localparam logic [2:0] B_Y_HI   = 3'd0;
	localparam logic [2:0] B_Y_LO   = 3'd1;
	localparam logic [2:0] B_RCP_HI = 3'd2;
	localparam logic [2:0] B_RCP_LO = 3'd3;
	localparam logic [2:0] B_MAG    = 3'd4;

	// Accumulator operation, applied in the cycle after the multiply issues
	localparam logic [2:0] OP_NONE    = 3'd0;
	localparam logic [2:0] OP_LOAD_Y  = 3'd1;
	localparam logic [2:0] OP_LOAD_HI = 3'd2;
	localparam logic [2:0] OP_ADD     = 3'd3;
	localparam logic [2:0] OP_ADD_SHR = 3'd4;

	// Jump conditions
	localparam logic [2:0] J_NEXT    = 3'd0;
	localparam logic [2:0] J_WAIT_IN = 3'd1;
	localparam logic [2:0] J_SKIP    = 3'd2;
	localparam logic [2:0] J_LOOP    = 3'd3;
	localparam logic [2:0] J_OUT     = 3'd4;

	typedef struct packed {
		logic [1:0]      a_sel;
		logic [2:0]      b_sel;
		logic [2:0]      acc_op;
		logic            term_wr;
		logic            sum_add;
		logic            r_inc;
		logic            out_wr;
		logic [2:0]      jmp;
		logic [PC_W-1:0] target;
	} ctl_word_t;

	// round(2^32 / r^2) by restoring long division; called with constants only
	function automatic logic [32:0] recip_q32(input int unsigned r);
		logic [12:0] sq;
		logic [33:0] num;
		logic [13:0] rem;
		logic [33:0] q;
		sq  = 13'(r * r);
		num = {2'b01, 32'b0} + 34'(sq >> 1);
		rem = '0;
		q   = '0;
		if (sq != 13'd0) begin
			for (int i = 33; i >= 0; i--) begin
				rem = {rem[12:0], num[i]};
				if (rem >= {1'b0, sq}) begin
					rem  = rem - {1'b0, sq};
					q[i] = 1'b1;
				end
			end
		end
		return q[32:0];
	endfunction

endpackage

[rtl/core/bessel_i0_series_eval_unit.sv]
// ----------------------------------------------------------------------------
// bessel_i0_series_eval_unit
// Zeroth-order modified Bessel I0(x) of a Q4.16 sample by truncated power
// series, result in unsigned Q10.22 with saturation.
// ----------------------------------------------------------------------------
// Timing: the program runs n = min(term_count, MAX_TERMS) terms per input; an
//   unsupported order or n = 0 skips straight to the result. One item at a time:
//   a new sample is taken only after the previous result enters the output slot;
//   each term is two 64-bit products of four 32x32 partial products each.
// Reset: arst_n clears control state and sets function_order to 0 and
//   term_count to 16; no clearing pass is needed.
module bessel_i0_series_eval_unit #(
	parameter int MAX_TERMS        = bsi0_pkg::DEF_MAX_TERMS,
	parameter int INPUT_FRAC_BITS  = bsi0_pkg::DEF_INPUT_FRAC_BITS,
	parameter int OUTPUT_FRAC_BITS = bsi0_pkg::DEF_OUTPUT_FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [bsi0_pkg::PADDR_W-1:0]        paddr,
	input  logic [bsi0_pkg::PDATA_W-1:0]        pwdata,
	output logic [bsi0_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [bsi0_pkg::X_W-1:0]     sample_x,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [bsi0_pkg::VALUE_W-1:0]        bessel_value,
	output logic [bsi0_pkg::STAT_W-1:0]         status
);
	import bsi0_pkg::*;

	localparam int RW = $clog2(MAX_TERMS + 1);

	logic [ORDER_W-1:0] function_order_q;
	logic [TERMS_W-1:0] term_count_q;
	logic               start;
	logic               can_out;
	logic               out_fire;
	logic               bad_order;
	logic [RW-1:0]      r_idx;
	ctl_word_t          ctl;
	logic [VALUE_W-1:0] res_value;
	logic [STAT_W-1:0]  res_status;
	logic               out_valid_q;
	logic [VALUE_W-1:0] bessel_value_q;
	logic [STAT_W-1:0]  status_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			function_order_q <= RST_FUNC_ORDER;
			term_count_q     <= RST_TERM_COUNT;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_FUNC_ORDER: function_order_q <= pwdata[ORDER_W-1:0];
				REG_TERM_COUNT: term_count_q     <= pwdata[TERMS_W-1:0];
				default:        function_order_q <= function_order_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_FUNC_ORDER: prdata = PDATA_W'(function_order_q);
			REG_TERM_COUNT: prdata = PDATA_W'(term_count_q);
			default:        prdata = '0;
		endcase
	end

	assign start   = in_valid && in_ready;
	assign can_out = !out_valid_q || out_ready;

	bsi0_useq #(
		.MAX_TERMS (MAX_TERMS)
	) u_useq (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.function_order (function_order_q),
		.term_count     (term_count_q),
		.can_out        (can_out),
		.ctl            (ctl),
		.r_idx          (r_idx),
		.bad_order      (bad_order),
		.in_ready       (in_ready),
		.out_fire       (out_fire)
	);

	bsi0_dpath #(
		.MAX_TERMS        (MAX_TERMS),
		.INPUT_FRAC_BITS  (INPUT_FRAC_BITS),
		.OUTPUT_FRAC_BITS (OUTPUT_FRAC_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.sample_x   (sample_x),
		.ctl        (ctl),
		.r_idx      (r_idx),
		.bad_order  (bad_order),
		.res_value  (res_value),
		.res_status (res_status)
	);

	// output slot: hold until transfer, load when the program finishes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire) begin
			bessel_value_q <= res_value;
			status_q       <= res_status;
		end
	end

	assign out_valid    = out_valid_q;
	assign bessel_value = bessel_value_q;
	assign status       = status_q;

endmodule

[rtl/core/bsi0_useq.sv]
// ----------------------------------------------------------------------------
// bsi0_useq
// Microcode sequencer: program counter, control ROM, term counter, jumps.
// ----------------------------------------------------------------------------
module bsi0_useq #(
	parameter int MAX_TERMS = bsi0_pkg::DEF_MAX_TERMS,
	localparam int RW = $clog2(MAX_TERMS + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [bsi0_pkg::ORDER_W-1:0]    function_order,
	input  logic [bsi0_pkg::TERMS_W-1:0]    term_count,
	input  logic                            can_out,
	output bsi0_pkg::ctl_word_t             ctl,
	output logic [RW-1:0]                   r_idx,
	output logic                            bad_order,
	output logic                            in_ready,
	output logic                            out_fire
);
	import bsi0_pkg::*;

	localparam logic [PC_W-1:0] PC_IDLE   = 4'd0;
	localparam logic [PC_W-1:0] PC_SQ     = 4'd1;
	localparam logic [PC_W-1:0] PC_SQ_W   = 4'd2;
	localparam logic [PC_W-1:0] PC_M1_HH  = 4'd3;
	localparam logic [PC_W-1:0] PC_M1_HL  = 4'd4;
	localparam logic [PC_W-1:0] PC_M1_LH  = 4'd5;
	localparam logic [PC_W-1:0] PC_M1_LL  = 4'd6;
	localparam logic [PC_W-1:0] PC_M1_W   = 4'd7;
	localparam logic [PC_W-1:0] PC_M2_HH  = 4'd8;
	localparam logic [PC_W-1:0] PC_M2_HL  = 4'd9;
	localparam logic [PC_W-1:0] PC_M2_LH  = 4'd10;
	localparam logic [PC_W-1:0] PC_M2_LL  = 4'd11;
	localparam logic [PC_W-1:0] PC_M2_W   = 4'd12;
	localparam logic [PC_W-1:0] PC_ACCUM  = 4'd13;
	localparam logic [PC_W-1:0] PC_FIN    = 4'd14;

	localparam logic [RW:0] MAX_N = (RW + 1)'(MAX_TERMS);

	function automatic ctl_word_t ucode(input logic [PC_W-1:0] pc);
		ctl_word_t cw;
		cw = '0;
		case (pc)
			PC_IDLE: begin
				cw.jmp = J_WAIT_IN;
			end
			PC_SQ: begin
				cw.a_sel  = A_MAG;
				cw.b_sel  = B_MAG;
				cw.acc_op = OP_LOAD_Y;
				cw.jmp    = J_SKIP;
				cw.target = PC_FIN;
			end
			PC_SQ_W: begin
				cw.jmp = J_NEXT;
			end
			PC_M1_HH: begin
				cw.a_sel  = A_TERM_HI;
				cw.b_sel  = B_Y_HI;
				cw.acc_op = OP_LOAD_HI;
			end
			PC_M1_HL: begin
				cw.a_sel  = A_TERM_HI;
				cw.b_sel  = B_Y_LO;
				cw.acc_op = OP_ADD;
			end
			PC_M1_LH: begin
				cw.a_sel  = A_TERM_LO;
				cw.b_sel  = B_Y_HI;
				cw.acc_op = OP_ADD;
			end
			PC_M1_LL: begin
				cw.a_sel   = A_TERM_LO;
				cw.b_sel   = B_Y_LO;
				cw.acc_op  = OP_ADD_SHR;
				cw.term_wr = 1'b1;
			end
			PC_M1_W: begin
				cw.jmp = J_NEXT;
			end
			PC_M2_HH: begin
				cw.a_sel  = A_TERM_HI;
				cw.b_sel  = B_RCP_HI;
				cw.acc_op = OP_LOAD_HI;
			end
			PC_M2_HL: begin
				cw.a_sel  = A_TERM_HI;
				cw.b_sel  = B_RCP_LO;
				cw.acc_op = OP_ADD;
			end
			PC_M2_LH: begin
				cw.a_sel  = A_TERM_LO;
				cw.b_sel  = B_RCP_HI;
				cw.acc_op = OP_ADD;
			end
			PC_M2_LL: begin
				cw.a_sel   = A_TERM_LO;
				cw.b_sel   = B_RCP_LO;
				cw.acc_op  = OP_ADD_SHR;
				cw.term_wr = 1'b1;
			end
			PC_M2_W: begin
				cw.jmp = J_NEXT;
			end
			PC_ACCUM: begin
				cw.sum_add = 1'b1;
				cw.r_inc   = 1'b1;
				cw.jmp     = J_LOOP;
				cw.target  = PC_M1_HH;
			end
			PC_FIN: begin
				cw.out_wr = 1'b1;
				cw.jmp    = J_OUT;
				cw.target = PC_IDLE;
			end
			default: begin
				cw.jmp    = J_OUT;
				cw.target = PC_IDLE;
			end
		endcase
		return cw;
	endfunction

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_d;
	logic [RW-1:0]   n_q;
	logic [RW-1:0]   r_q;
	logic            bad_q;
	logic            skip;
	logic [RW-1:0]   n_sel;

	assign ctl       = ucode(pc_q);
	assign r_idx     = r_q;
	assign bad_order = bad_q;
	assign in_ready  = (pc_q == PC_IDLE);
	assign out_fire  = ctl.out_wr && can_out;
	assign skip      = bad_q || (n_q == '0);

	// clamp the configured count to MAX_TERMS
	always_comb begin
		if ((RW + 1)'(term_count) > MAX_N) begin
			n_sel = RW'(MAX_TERMS);
		end else begin
			n_sel = RW'(term_count);
		end
	end

	always_comb begin
		case (ctl.jmp)
			J_NEXT:    pc_d = pc_q + 1'b1;
			J_WAIT_IN: pc_d = start ? pc_q + 1'b1 : pc_q;
			J_SKIP:    pc_d = skip ? ctl.target : pc_q + 1'b1;
			J_LOOP:    pc_d = (r_q != n_q) ? ctl.target : pc_q + 1'b1;
			J_OUT:     pc_d = can_out ? ctl.target : pc_q;
			default:   pc_d = PC_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= PC_IDLE;
			n_q   <= '0;
			r_q   <= '0;
			bad_q <= 1'b0;
		end else begin
			pc_q <= pc_d;
			if (start) begin
				n_q   <= n_sel;
				r_q   <= RW'(1);
				bad_q <= (function_order != '0);
			end else if (ctl.r_inc) begin
				r_q <= r_q + 1'b1;
			end
		end
	end

endmodule

[rtl/core/bsi0_dpath.sv]
// ----------------------------------------------------------------------------
// bsi0_dpath
// Shared 32x32 multiplier, partial-product accumulator, term and sum
// registers, reciprocal table and output rounding.
// ----------------------------------------------------------------------------
module bsi0_dpath #(
	parameter int MAX_TERMS        = bsi0_pkg::DEF_MAX_TERMS,
	parameter int INPUT_FRAC_BITS  = bsi0_pkg::DEF_INPUT_FRAC_BITS,
	parameter int OUTPUT_FRAC_BITS = bsi0_pkg::DEF_OUTPUT_FRAC_BITS,
	localparam int RW = $clog2(MAX_TERMS + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [bsi0_pkg::X_W-1:0]     sample_x,
	input  bsi0_pkg::ctl_word_t                 ctl,
	input  logic [RW-1:0]                       r_idx,
	input  logic                                bad_order,
	output logic [bsi0_pkg::VALUE_W-1:0]        res_value,
	output logic [bsi0_pkg::STAT_W-1:0]         res_status
);
	import bsi0_pkg::*;

	localparam int YSH = 2 * INPUT_FRAC_BITS + 2 - WORK_FRAC;
	localparam int RSH = WORK_FRAC - OUTPUT_FRAC_BITS;
	localparam int TAB_N = 2 ** RW;

	logic [32:0]      rcp_tab [TAB_N];
	logic [32:0]      rcp;
	logic [X_W-1:0]   mag;
	logic [X_W-1:0]   mag_q;
	logic [63:0]      y_q;
	logic [63:0]      term_q;
	logic [63:0]      sum_q;
	logic [63:0]      acc_q;
	logic             ovf_q;
	logic [31:0]      a_op;
	logic [31:0]      b_op;
	logic [63:0]      prod;
	logic [63:0]      p_s1;
	logic [2:0]       op_s1;
	logic             twr_s1;
	logic [64:0]      acc_sum;
	logic [63:0]      acc_d;
	logic             acc_ovf;
	logic [64:0]      sum_new;
	logic [63:0]      y_new;
	logic [63:0]      res;

	for (genvar g = 0; g < TAB_N; g++) begin : g_rcp
		assign rcp_tab[g] = recip_q32(g);
	end
	assign rcp = rcp_tab[r_idx];

	// magnitude of the two's complement sample; the most negative value maps to 2^19
	assign mag = sample_x[X_W-1] ? (~sample_x + 1'b1) : sample_x;

	if (YSH >= 0) begin : g_y_shr
		assign y_new = p_s1 >> YSH;
	end else begin : g_y_shl
		assign y_new = p_s1 << (-YSH);
	end

	always_comb begin
		case (ctl.a_sel)
			A_TERM_HI: a_op = term_q[63:32];
			A_TERM_LO: a_op = term_q[31:0];
			A_MAG:     a_op = 32'(mag_q);
			default:   a_op = '0;
		endcase
		case (ctl.b_sel)
			B_Y_HI:   b_op = y_q[63:32];
			B_Y_LO:   b_op = y_q[31:0];
			B_RCP_HI: b_op = 32'(rcp[32]);
			B_RCP_LO: b_op = rcp[31:0];
			B_MAG:    b_op = 32'(mag_q);
			default:  b_op = '0;
		endcase
	end

	assign prod = a_op * b_op;

	// a nonzero high half on load or overflow of any partial add means the full product left 64 bits
	always_comb begin
		acc_sum = '0;
		acc_d   = acc_q;
		acc_ovf = 1'b0;
		case (op_s1)
			OP_LOAD_HI: begin
				acc_d   = {p_s1[31:0], 32'b0};
				acc_ovf = (p_s1[63:32] != '0);
			end
			OP_ADD: begin
				acc_sum = {1'b0, acc_q} + {1'b0, p_s1};
				acc_d   = acc_sum[63:0];
				acc_ovf = acc_sum[64];
			end
			OP_ADD_SHR: begin
				acc_sum = {1'b0, acc_q} + {33'b0, p_s1[63:32]};
				acc_d   = acc_sum[63:0];
				acc_ovf = acc_sum[64];
			end
			default: begin
				acc_d = acc_q;
			end
		endcase
	end

	assign sum_new = {1'b0, sum_q} + {1'b0, term_q};

	always_ff @(posedge clk) begin
		p_s1  <= prod;
		acc_q <= acc_d;
		if (op_s1 == OP_LOAD_Y) begin
			y_q <= y_new;
		end
		if (start) begin
			mag_q  <= mag;
			term_q <= 64'(1) << WORK_FRAC;
			sum_q  <= 64'(1) << WORK_FRAC;
		end else begin
			if (twr_s1) begin
				term_q <= acc_d;
			end
			if (ctl.sum_add) begin
				sum_q <= sum_new[63:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1  <= OP_NONE;
			twr_s1 <= 1'b0;
			ovf_q  <= 1'b0;
		end else begin
			op_s1  <= ctl.acc_op;
			twr_s1 <= ctl.term_wr;
			if (start) begin
				ovf_q <= 1'b0;
			end else if (acc_ovf || (ctl.sum_add && sum_new[64])) begin
				ovf_q <= 1'b1;
			end
		end
	end

	// round half up to the output fraction width
	assign res = (sum_q >> RSH) + 64'(sum_q[RSH-1]);

	always_comb begin
		if (bad_order) begin
			res_value  = '0;
			res_status = ST_BAD_ORDER;
		end else if (ovf_q || (res[63:32] != '0)) begin
			res_value  = '1;
			res_status = ST_SAT;
		end else begin
			res_value  = res[31:0];
			res_status = ST_OK;
		end
	end

endmodule

[rtl/core/bsi0_chk.sv]
// ----------------------------------------------------------------------------
// bsi0_chk
// Port-level checks for the I0 series evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module bsi0_chk (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [bsi0_pkg::VALUE_W-1:0]     bessel_value,
	input logic [bsi0_pkg::STAT_W-1:0]      status
);
	import bsi0_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bessel_value) && $stable(status))
		else $error("result changed while stalled");

	// one item in flight: no new transfer right after one
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_BAD_ORDER) |-> bessel_value == '0)
		else $error("unsupported order with nonzero value");

	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_SAT) |-> bessel_value == '1)
		else $error("saturated status without full-scale value");

endmodule

bind bessel_i0_series_eval_unit bsi0_chk u_chk (.*);
